@@ sv/apr_pkg.sv @@
package apr_pkg;

    // Built sizes used as defaults by the top level.
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 20;
    localparam int AGE_BITS_DEF  = 8;

    // Fixed field widths of the ports.
    localparam int ACTIVE_W     = 5;
    localparam int FRAME_USED_W = 4;

    // Register file of the configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_ACTIVE_FRAMES = 3'd0;
    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET      = 5'd16;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic step;
    } apr_scan_ctl_t;

endpackage

@@ sv/apr_ref_if.sv @@
interface apr_ref_if #(
    parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

@@ sv/apr_res_if.sv @@
interface apr_res_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [apr_pkg::FRAME_USED_W-1:0] frame_used;

    modport source (output valid, output hit, output frame_used, input ready);
    modport sink   (input valid, input hit, input frame_used, output ready);
endinterface

@@ sv/aging_page_replacement_core.sv @@
// Aging page replacement core.
// page_ref carries one page reference per request; result returns, for each
// reference, whether the page was resident (hit) and the frame that now holds
// it (frame_used). Both channels use valid/ready; a request moves when both
// are high at a rising edge.
// The APB port holds one register, active_frames at address 0 (reset 16),
// clamped to 1..FRAMES. Write it only while no reference is in flight.
// For each reference, with n the number of active frames, the frames are
// read one per cycle from the frame store, and a single compare unit checks
// each for a page match, a free slot and the smallest age while the shifted
// age is written back. The ST_FIX state then writes the chosen frame.
// page_ref is ready only while the core is idle, so a new reference is taken
// only once the last one has been loaded into the result register.
// The result register lets the next reference be accepted while the last
// result is still waiting; if result stalls, the core holds in its final
// step until the output register is free.
// Reset marks every frame free and sets active_frames to 16; no clearing
// pass is needed.
module aging_page_replacement_core #(
    parameter int FRAMES    = apr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF,
    parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    apr_ref_if.sink                        page_ref,
    apr_res_if.source                      result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [apr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [apr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (CNT_W > apr_pkg::ACTIVE_W) ? CNT_W : apr_pkg::ACTIVE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FIX
    } state_t;

    state_t                     state_reg;
    logic [apr_pkg::ACTIVE_W-1:0] active_reg;
    logic [PAGE_BITS-1:0]       page_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       rd_pending_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic [apr_pkg::FRAME_USED_W-1:0] out_frame_reg;

    logic                       accept;
    logic                       load_out;
    logic [CNT_W-1:0]           live_n;
    logic [CMP_W-1:0]           active_ext;
    apr_pkg::apr_scan_ctl_t     scan_ctl;
    logic                       rd_en;
    logic [PAGE_BITS-1:0]       rd_page;
    logic [AGE_BITS-1:0]        rd_age;
    logic                       rd_valid;
    logic [AGE_BITS-1:0]        wb_age;
    logic                       scan_hit;
    logic [IDX_W-1:0]           chosen;
    logic [AGE_BITS-1:0]        chosen_age;
    logic                       age_we;
    logic [IDX_W-1:0]           age_waddr;
    logic [AGE_BITS-1:0]        age_wdata;
    logic                       fix;
    logic                       cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == apr_pkg::REG_ACTIVE_FRAMES);
    assign prdata    = (paddr == apr_pkg::REG_ACTIVE_FRAMES)
                     ? apr_pkg::APB_DATA_W'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= apr_pkg::ACTIVE_RESET;
        end
        else if (cfg_write)
        begin
            active_reg <= pwdata[apr_pkg::ACTIVE_W-1:0];
        end
    end

    // Zero counts as one frame, anything above the built count as all frames.
    assign active_ext = CMP_W'(active_reg);
    always_comb
    begin
        priority if (active_ext == '0)
        begin
            live_n = CNT_W'(1);
        end
        else if (active_ext > CMP_W'(FRAMES))
        begin
            live_n = CNT_W'(FRAMES);
        end
        else
        begin
            live_n = CNT_W'(active_ext);
        end
    end

    assign page_ref.ready = (state_reg == ST_IDLE);
    assign accept         = page_ref.valid && page_ref.ready;
    assign fix            = (state_reg == ST_FIX);
    assign load_out       = fix && (!out_valid_reg || result.ready);
    assign rd_en          = (state_reg == ST_SCAN);
    assign scan_ctl.clear = accept;
    assign scan_ctl.step  = rd_pending_reg;

    assign age_we    = rd_pending_reg || fix;
    assign age_waddr = fix ? chosen : rd_idx_reg;
    assign age_wdata = fix ? chosen_age : wb_age;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            n_reg          <= CNT_W'(1);
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_pending_reg <= rd_en;
            rd_idx_reg     <= cnt_reg[IDX_W-1:0];
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_hit_reg   <= scan_hit;
                out_frame_reg <= apr_pkg::FRAME_USED_W'(chosen);
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        page_reg  <= page_ref.page_number;
                        n_reg     <= live_n;
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == n_reg - CNT_W'(1))
                    begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST:
                begin
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.hit        = out_hit_reg;
    assign result.frame_used = out_frame_reg;

    apr_frame_store #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (cnt_reg[IDX_W-1:0]),
        .rd_page    (rd_page),
        .rd_age     (rd_age),
        .rd_valid   (rd_valid),
        .age_we     (age_we),
        .age_waddr  (age_waddr),
        .age_wdata  (age_wdata),
        .page_we    (fix),
        .page_waddr (chosen),
        .page_wdata (page_reg)
    );

    apr_scan_unit #(
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS),
        .IDX_W     (IDX_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .step_idx    (rd_idx_reg),
        .target_page (page_reg),
        .frame_valid (rd_valid),
        .frame_page  (rd_page),
        .frame_age   (rd_age),
        .wb_age      (wb_age),
        .hit         (scan_hit),
        .chosen      (chosen),
        .chosen_age  (chosen_age)
    );

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg < n_reg))
        else $error("scan index beyond active frames");

    a_chosen_active: assert property (@(posedge clk) disable iff (!rst_n)
        fix |-> (CNT_W'(chosen) < n_reg))
        else $error("chosen frame is not active");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> ((state_reg == ST_SCAN) || (state_reg == ST_LAST)))
        else $error("frame data returned outside the scan");

endmodule

@@ sv/apr_frame_store.sv @@
module apr_frame_store #(
    parameter int FRAMES    = apr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF,
    parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF,
    parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [PAGE_BITS-1:0] rd_page,
    output logic [AGE_BITS-1:0]  rd_age,
    output logic                 rd_valid,
    input  logic                 age_we,
    input  logic [IDX_W-1:0]     age_waddr,
    input  logic [AGE_BITS-1:0]  age_wdata,
    input  logic                 page_we,
    input  logic [IDX_W-1:0]     page_waddr,
    input  logic [PAGE_BITS-1:0] page_wdata
);

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [AGE_BITS-1:0]  age_mem  [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic [AGE_BITS-1:0]  rd_age_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_waddr] <= page_wdata;
        end
        if (age_we)
        begin
            age_mem[age_waddr] <= age_wdata;
        end
        if (rd_en)
        begin
            rd_page_reg <= page_mem[rd_addr];
            rd_age_reg  <= age_mem[rd_addr];
        end
    end

    // Valid bits are flops so that reset frees every frame at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (page_we)
            begin
                valid_reg[page_waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_page  = rd_page_reg;
    assign rd_age   = rd_age_reg;
    assign rd_valid = rd_valid_reg;

    a_written_frame_valid: assert property (@(posedge clk) disable iff (!rst_n)
        page_we |=> valid_reg[$past(page_waddr)])
        else $error("frame not valid after page write");

endmodule

@@ sv/apr_scan_unit.sv @@
module apr_scan_unit #(
    parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF,
    parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF,
    parameter int IDX_W     = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  apr_pkg::apr_scan_ctl_t ctl,
    input  logic [IDX_W-1:0]       step_idx,
    input  logic [PAGE_BITS-1:0]   target_page,
    input  logic                   frame_valid,
    input  logic [PAGE_BITS-1:0]   frame_page,
    input  logic [AGE_BITS-1:0]    frame_age,
    output logic [AGE_BITS-1:0]    wb_age,
    output logic                   hit,
    output logic [IDX_W-1:0]       chosen,
    output logic [AGE_BITS-1:0]    chosen_age
);

    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    logic                hit_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [AGE_BITS-1:0] hit_age_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                first_reg;
    logic [IDX_W-1:0]    min_idx_reg;
    logic [AGE_BITS-1:0] min_age_reg;
    logic                page_match;
    logic                age_less;
    logic [AGE_BITS-1:0] src_age;

    assign page_match = frame_valid && (frame_page == target_page);
    assign age_less   = frame_age < min_age_reg;

    // A free frame has never been touched, so its age is zero.
    assign wb_age = frame_valid ? (frame_age >> 1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            first_reg      <= 1'b1;
        end
        else if (ctl.clear)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            first_reg      <= 1'b1;
        end
        else if (ctl.step)
        begin
            first_reg <= 1'b0;
            if (!hit_found_reg && page_match)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= step_idx;
                hit_age_reg   <= frame_age;
            end
            if (!free_found_reg && !frame_valid)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= step_idx;
            end
            // Ties keep the lower index.
            if (first_reg || age_less)
            begin
                min_idx_reg <= step_idx;
                min_age_reg <= frame_age;
            end
        end
    end

    always_comb
    begin
        priority if (hit_found_reg)
        begin
            chosen  = hit_idx_reg;
            src_age = hit_age_reg;
        end
        else if (free_found_reg)
        begin
            chosen  = free_idx_reg;
            src_age = '0;
        end
        else
        begin
            chosen  = min_idx_reg;
            src_age = min_age_reg;
        end
    end

    assign hit        = hit_found_reg;
    assign chosen_age = (src_age >> 1) | AGE_TOP;

    a_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_found_reg && !ctl.clear) |=> (hit_found_reg && $stable(hit_idx_reg)))
        else $error("hit frame changed during scan");

endmodule
